// ===== src/rbo_pkg.sv =====
// Shared types and constants for the overwrite-capable ring buffer.
// Holds the operation codes, controller states and the command/status structs.
// No dependencies.
package rbo_pkg;

  localparam int DATA_BITS     = 32;
  localparam int CNT_BITS      = 5;
  localparam int INDEX_BITS    = 16;
  localparam int MODE_BITS     = 2;
  localparam int DIV_CNT_BITS  = $clog2(INDEX_BITS);
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_PEEK  = 2'd1,
    MODE_POP   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC,
    ST_PEEK_RD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic exec;
    logic peek_rd;
  } cmd_t;

  typedef struct packed {
    logic go_div;
    logic div_last;
  } status_t;

endpackage

// ===== src/rbo_ctrl.sv =====
// Controller state machine for the ring buffer.
// Depends on rbo_pkg; drives rbo_datapath through cmd_t and reads status_t.
module rbo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rbo_pkg::status_t status,
  output rbo_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  import rbo_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = status.go_div ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_PEEK_RD;
        end
      end
      ST_EXEC:    state_next = ST_RESP;
      ST_PEEK_RD: state_next = ST_RESP;
      ST_RESP:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIV:     cmd.div_step = 1'b1;
      ST_EXEC:    cmd.exec     = 1'b1;
      ST_PEEK_RD: cmd.peek_rd  = 1'b1;
      ST_RESP:    done         = 1'b1;
      default:    busy         = 1'b1;
    endcase
  end

endmodule

// ===== src/rbo_datapath.sv =====
// Datapath of the ring buffer: word storage, pointers, count, capacity register,
// the bit-serial remainder unit for peek, and the result registers. Depends on rbo_pkg.
module rbo_datapath #(
  parameter int DEPTH     = rbo_pkg::DEPTH_DEF,
  parameter int WORD_BITS = rbo_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rbo_pkg::cmd_t                  cmd,
  output rbo_pkg::status_t               status,
  input  logic                           cfg_we,
  input  logic [rbo_pkg::CNT_BITS-1:0]   cfg_data,
  input  logic [rbo_pkg::MODE_BITS-1:0]  mode,
  input  logic [rbo_pkg::DATA_BITS-1:0]  data_in,
  input  logic                           overwrite,
  input  logic [rbo_pkg::INDEX_BITS-1:0] index,
  output logic                           ok,
  output logic [rbo_pkg::DATA_BITS-1:0]  data_out,
  output logic [rbo_pkg::CNT_BITS-1:0]   used_count,
  output logic [rbo_pkg::CNT_BITS-1:0]   free_count,
  output logic                           is_empty,
  output logic                           is_full
);
  import rbo_pkg::*;

  // The 5-bit capacity register can never select more than 31 entries.
  localparam int CAP_LIMIT  = (1 << CNT_BITS) - 1;
  localparam int CAP_MAX    = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
  localparam int CAP_RST    = (DEPTH < 16) ? DEPTH : 16;
  localparam int MEM_DEPTH  = CAP_MAX;
  localparam int PTR_BITS   = $clog2(MEM_DEPTH);
  localparam int STORE_BITS = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;
  localparam int SUM_BITS   = CNT_BITS + 1;

  localparam logic [CNT_BITS-1:0] CAP_MAX_V = CNT_BITS'(CAP_MAX);
  localparam logic [CNT_BITS-1:0] CAP_RST_V = CNT_BITS'(CAP_RST);

  logic [STORE_BITS-1:0] mem [MEM_DEPTH];
  logic [STORE_BITS-1:0] rdata;

  logic [PTR_BITS-1:0]   head;
  logic [PTR_BITS-1:0]   tail;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   capacity;

  mode_t                 op;
  logic [DATA_BITS-1:0]  data_q;
  logic                  ovw_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic [CNT_BITS-1:0]   rem;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic                  ok_q;
  logic                  rd_sel;

  logic [CNT_BITS-1:0]   head_inc;
  logic [CNT_BITS-1:0]   tail_inc;
  logic [PTR_BITS-1:0]   head_adv;
  logic [PTR_BITS-1:0]   tail_adv;
  logic                  full;
  logic                  push_ok;
  logic                  pop_ok;
  logic [SUM_BITS-1:0]   trial;
  logic                  fits;
  logic [CNT_BITS-1:0]   rem_next;
  logic [SUM_BITS-1:0]   pos_sum;
  logic [SUM_BITS-1:0]   pos_wrap;
  logic [PTR_BITS-1:0]   peek_addr;
  logic [CNT_BITS-1:0]   cap_in;

  assign full     = (count == capacity);
  assign head_inc = CNT_BITS'(head) + CNT_BITS'(1);
  assign tail_inc = CNT_BITS'(tail) + CNT_BITS'(1);
  assign head_adv = (head_inc >= capacity) ? '0 : PTR_BITS'(head_inc);
  assign tail_adv = (tail_inc >= capacity) ? '0 : PTR_BITS'(tail_inc);
  assign push_ok  = cmd.exec && (op == MODE_PUSH) && (!full || ovw_q);
  assign pop_ok   = cmd.exec && (op == MODE_POP) && (count != '0);

  // One restoring step per cycle, index bits taken from the top down.
  assign trial    = {rem, idx_q[INDEX_BITS-1]};
  assign fits     = (trial >= SUM_BITS'(count));
  assign rem_next = fits ? CNT_BITS'(trial - SUM_BITS'(count)) : CNT_BITS'(trial);

  assign pos_sum  = SUM_BITS'(head) + SUM_BITS'(rem);
  assign pos_wrap = (pos_sum >= SUM_BITS'(capacity)) ? pos_sum - SUM_BITS'(capacity)
                                                      : pos_sum;
  assign peek_addr = PTR_BITS'(pos_wrap);

  always_comb begin
    cap_in = cfg_data;
    if (cfg_data == '0) begin
      cap_in = CNT_BITS'(1);
    end else if (cfg_data > CAP_MAX_V) begin
      cap_in = CAP_MAX_V;
    end
  end

  assign status.go_div   = (mode_t'(mode) == MODE_PEEK) && (count != '0);
  assign status.div_last = (div_cnt == DIV_CNT_BITS'(INDEX_BITS - 1));

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= data_q[STORE_BITS-1:0];
    end
    if (cmd.peek_rd) begin
      rdata <= mem[peek_addr];
    end else if (pop_ok) begin
      rdata <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      capacity <= CAP_RST_V;
    end else if (cfg_we) begin
      capacity <= cap_in;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else if (cmd.exec) begin
      case (op)
        MODE_PUSH: begin
          if (!full || ovw_q) begin
            tail <= tail_adv;
            if (full) begin
              head <= head_adv;
            end else begin
              count <= count + CNT_BITS'(1);
            end
          end
        end
        MODE_POP: begin
          if (count != '0) begin
            head  <= head_adv;
            count <= count - CNT_BITS'(1);
          end
        end
        MODE_CLEAR: begin
          head  <= '0;
          tail  <= '0;
          count <= '0;
        end
        default: begin
          head <= head;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= mode_t'(mode);
      data_q  <= data_in;
      ovw_q   <= overwrite;
      idx_q   <= index;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_next;
      idx_q   <= {idx_q[INDEX_BITS-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_BITS'(1);
    end
    if (cmd.peek_rd) begin
      ok_q   <= 1'b1;
      rd_sel <= 1'b1;
    end else if (cmd.exec) begin
      case (op)
        MODE_PUSH: begin
          ok_q   <= !full || ovw_q;
          rd_sel <= 1'b0;
        end
        MODE_POP: begin
          ok_q   <= (count != '0);
          rd_sel <= (count != '0);
        end
        MODE_CLEAR: begin
          ok_q   <= 1'b1;
          rd_sel <= 1'b0;
        end
        default: begin
          // A peek only reaches this state when the buffer is empty.
          ok_q   <= 1'b0;
          rd_sel <= 1'b0;
        end
      endcase
    end
  end

  assign ok         = ok_q;
  assign data_out   = rd_sel ? DATA_BITS'(rdata) : '0;
  assign used_count = count;
  assign free_count = capacity - count;
  assign is_empty   = (count == '0);
  assign is_full    = full;

endmodule

// ===== src/ring_buffer_overwrite_indexed_unit.sv =====
// Top level of the overwrite-capable ring buffer with indexed peek.
// Depends on rbo_pkg, rbo_ctrl and rbo_datapath.
//
// An operation is taken when start is high while busy is low. Push, pop, clear
// and a peek on an empty buffer go from the execute state to the response state,
// which raises done. A peek on a non-empty buffer goes through the divide,
// peek-read and response states. The position modulo the count comes from a
// remainder unit that retires one of the sixteen index bits per cycle, followed
// by one registered memory read. done is high for exactly one cycle and the
// receiver cannot stall it; ok and data_out are valid in that cycle and hold
// until a later operation writes them. busy drops in the cycle after done, so a
// new operation is taken only once the last one is done. The storage needs no
// clearing pass after reset. Writing the capacity also empties the buffer; the
// user must write it only while busy is low, as the block does not enforce it.
module ring_buffer_overwrite_indexed_unit #(
  parameter int DEPTH     = rbo_pkg::DEPTH_DEF,
  parameter int WORD_BITS = rbo_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           cfg_we,
  input  logic [rbo_pkg::CNT_BITS-1:0]   cfg_data,
  input  logic [rbo_pkg::MODE_BITS-1:0]  mode,
  input  logic [rbo_pkg::DATA_BITS-1:0]  data_in,
  input  logic                           overwrite,
  input  logic [rbo_pkg::INDEX_BITS-1:0] index,
  output logic                           ok,
  output logic [rbo_pkg::DATA_BITS-1:0]  data_out,
  output logic [rbo_pkg::CNT_BITS-1:0]   used_count,
  output logic [rbo_pkg::CNT_BITS-1:0]   free_count,
  output logic                           is_empty,
  output logic                           is_full
);
  import rbo_pkg::*;

  cmd_t    cmd;
  status_t status;

  rbo_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rbo_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .data_in    (data_in),
    .overwrite  (overwrite),
    .index      (index),
    .ok         (ok),
    .data_out   (data_out),
    .used_count (used_count),
    .free_count (free_count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

endmodule
